// File: design/pta_pkg.sv
// Shared types and constants of the primitive topology assembler.
// No dependencies; every other file of the block imports this package.
package pta_pkg;

  localparam int unsigned INDEX_BITS  = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // primitive_mode codes
  localparam logic [2:0] MODE_POINTS = 3'd0;
  localparam logic [2:0] MODE_LINES  = 3'd1;
  localparam logic [2:0] MODE_TRIS   = 3'd2;
  localparam logic [2:0] MODE_STRIP  = 3'd3;
  localparam logic [2:0] MODE_LOOP   = 3'd4;
  localparam logic [2:0] MODE_TSTRIP = 3'd5;
  localparam logic [2:0] MODE_FAN    = 3'd6;
  localparam logic [2:0] MODE_RESET  = MODE_TRIS;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_COUNT    = 2'd1;
  localparam logic [1:0] ST_BAD_MODE = 2'd2;

  // register indexes
  localparam logic REG_MODE = 1'b0;

  typedef logic [INDEX_BITS-1:0] index_t;

  typedef struct packed {
    index_t     a;
    index_t     b;
    index_t     c;
    logic [1:0] n;
    logic       last;
    logic [1:0] status;
  } result_t;

  // One queue entry: all results caused by one input item.
  typedef struct packed {
    result_t r0;
    result_t r1;
    logic    pair;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

endpackage

// File: design/primitive_topology_assembler_top.sv
// Top level of the primitive topology assembler: register port, front, queue, back.
// Depends on pta_pkg, pta_front, pta_fifo and pta_back.
//
//   channel   signals                                 direction
//   --------  --------------------------------------  ---------
//   in        in_valid_i/in_ready_o, index + end      input
//   out       out_valid_o/out_ready_i, face + status  output
//   cfg       APB psel/penable/pwrite/paddr/pwdata    input
//
// Flow: one index transfer per cycle unless the queue is full; each result
// leaves through a registered output that is loaded from the queue head.
// A closed line loop yields two results, so its entry stays at the queue
// head until both are loaded. Reset: mode returns to triangles, list state clears.
// Stalls: a four-entry queue absorbs output stalls; input ready drops only
// when the queue is full.
module primitive_topology_assembler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] vertex_index_i,
  input  logic        end_of_list_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] vertex_a_o,
  output logic [31:0] vertex_b_o,
  output logic [31:0] vertex_c_o,
  output logic [1:0]  vertices_in_face_o,
  output logic        last_result_o,
  output logic [1:0]  status_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pta_pkg::*;

  logic [2:0] mode_q;
  logic       cfg_wr;
  push_t      push;
  logic       full, empty, pop;
  entry_t     head;
  result_t    res;

  // Register file: a single mode register at byte address zero.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MODE) ? {29'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
    end else if (cfg_wr && paddr[2] == REG_MODE) begin
      mode_q <= pwdata[2:0];
    end
  end

  // Front: classify each index under the current mode.
  pta_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (mode_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .vertex_i   (vertex_index_i[INDEX_BITS-1:0]),
    .end_i      (end_of_list_i),
    .full_i     (full),
    .push_o     (push)
  );

  // Queue: hold entries so front and back stall independently.
  pta_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  // Back: advance through results one transfer at a time.
  pta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res)
  );

  // Zero-extend stored indices to the port width.
  assign vertex_a_o         = 32'(res.a);
  assign vertex_b_o         = 32'(res.b);
  assign vertex_c_o         = 32'(res.c);
  assign vertices_in_face_o = res.n;
  assign last_result_o      = res.last;
  assign status_o           = res.status;

endmodule

// File: design/pta_front.sv
// Front part: accepts vertex indices, tracks list state and builds face entries.
// Depends on pta_pkg.
module pta_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0]          mode_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pta_pkg::index_t     vertex_i,
  input  logic                end_i,
  input  logic                full_i,
  output pta_pkg::push_t      push_o
);
  import pta_pkg::*;

  index_t     first_q, first_d, older_q, older_d, newer_q, newer_d;
  logic [1:0] seen_q, seen_d, phase_q, phase_d;
  logic       wind_q, wind_d;
  logic       accept;
  index_t     first;
  result_t    r0, r1;
  logic [1:0] cnt;
  logic       err;
  logic [1:0] st;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign first      = (seen_q == 2'd0) ? vertex_i : first_q;

  always_comb begin
    r0      = '0;
    r1      = '0;
    cnt     = 2'd0;
    err     = 1'b0;
    st      = ST_OK;
    phase_d = 2'd0;
    wind_d  = wind_q;
    unique case (mode_i)
      MODE_POINTS: begin
        r0  = '{a: vertex_i, b: '0, c: '0, n: 2'd1, last: 1'b0, status: ST_OK};
        cnt = 2'd1;
      end
      MODE_LINES: begin
        if (phase_q[0]) begin
          r0  = '{a: newer_q, b: vertex_i, c: '0, n: 2'd2, last: 1'b0, status: ST_OK};
          cnt = 2'd1;
        end else begin
          phase_d = 2'd1;
          err     = end_i;
          st      = ST_COUNT;
        end
      end
      MODE_TRIS: begin
        if (phase_q >= 2'd2) begin
          r0  = '{a: older_q, b: newer_q, c: vertex_i, n: 2'd3, last: 1'b0,
                  status: ST_OK};
          cnt = 2'd1;
        end else begin
          phase_d = 2'(phase_q + 2'd1);
          err     = end_i;
          st      = ST_COUNT;
        end
      end
      MODE_STRIP, MODE_LOOP: begin
        if (seen_q >= 2'd1) begin
          r0  = '{a: newer_q, b: vertex_i, c: '0, n: 2'd2, last: 1'b0, status: ST_OK};
          cnt = 2'd1;
          if (end_i && mode_i == MODE_LOOP) begin
            // close the loop back to the first index
            r1  = '{a: vertex_i, b: first, c: '0, n: 2'd2, last: 1'b0, status: ST_OK};
            cnt = 2'd2;
          end
        end else begin
          err = end_i;
          st  = ST_COUNT;
        end
      end
      MODE_TSTRIP: begin
        if (seen_q >= 2'd2) begin
          if (wind_q) begin
            r0 = '{a: older_q, b: newer_q, c: vertex_i, n: 2'd3, last: 1'b0,
                   status: ST_OK};
          end else begin
            r0 = '{a: older_q, b: vertex_i, c: newer_q, n: 2'd3, last: 1'b0,
                   status: ST_OK};
          end
          cnt    = 2'd1;
          wind_d = !wind_q;
        end else begin
          err = end_i;
          st  = ST_COUNT;
        end
      end
      MODE_FAN: begin
        if (seen_q >= 2'd2) begin
          r0  = '{a: first, b: newer_q, c: vertex_i, n: 2'd3, last: 1'b0, status: ST_OK};
          cnt = 2'd1;
        end else begin
          err = end_i;
          st  = ST_COUNT;
        end
      end
      default: begin
        err = end_i;
        st  = ST_BAD_MODE;
      end
    endcase

    // errors only arise where no face was built
    if (end_i) begin
      if (err) begin
        r0  = '{a: '0, b: '0, c: '0, n: 2'd0, last: 1'b1, status: st};
        cnt = 2'd1;
      end else if (cnt == 2'd2) begin
        r1.last = 1'b1;
      end else begin
        r0.last = 1'b1;
      end
    end

    if (end_i) begin
      first_d = '0;
      older_d = '0;
      newer_d = '0;
      seen_d  = 2'd0;
      phase_d = 2'd0;
      wind_d  = 1'b1;
    end else begin
      first_d = first;
      older_d = newer_q;
      newer_d = vertex_i;
      seen_d  = (seen_q == 2'd3) ? seen_q : 2'(seen_q + 2'd1);
    end
  end

  assign push_o.push        = accept && (cnt != 2'd0);
  assign push_o.entry.r0    = r0;
  assign push_o.entry.r1    = r1;
  assign push_o.entry.pair  = (cnt == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      older_q <= '0;
      newer_q <= '0;
      seen_q  <= 2'd0;
      phase_q <= 2'd0;
      wind_q  <= 1'b1;
    end else if (accept) begin
      first_q <= first_d;
      older_q <= older_d;
      newer_q <= newer_d;
      seen_q  <= seen_d;
      phase_q <= phase_d;
      wind_q  <= wind_d;
    end
  end

endmodule

// File: design/pta_fifo.sv
// Short entry queue between the front and back parts.
// Depends on pta_pkg.
module pta_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pta_pkg::push_t  push_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output pta_pkg::entry_t head_o
);
  import pta_pkg::*;

  entry_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0] count_q;

  assign full_o  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.push) begin
        wr_ptr_q <= QPTR_BITS'(wr_ptr_q + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_q <= QPTR_BITS'(rd_ptr_q + 1'b1);
      end
      if (push_i.push && !pop_i) begin
        count_q <= QCNT_BITS'(count_q + 1'b1);
      end else if (pop_i && !push_i.push) begin
        count_q <= QCNT_BITS'(count_q - 1'b1);
      end
    end
  end

endmodule

// File: design/pta_back.sv
// Back part: drains queue entries and presents one result per transfer.
// Depends on pta_pkg.
module pta_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  pta_pkg::entry_t  head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pta_pkg::result_t out_o
);
  import pta_pkg::*;

  logic    valid_q;
  logic    sel_q;
  result_t out_q;
  logic    load;
  logic    second;

  assign load        = !valid_q || out_ready_i;
  assign second      = head_i.pair && !sel_q;
  assign pop_o       = load && !empty_i && !second;
  assign out_valid_o = valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      out_q <= sel_q ? head_i.r1 : head_i.r0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (load) begin
      valid_q <= !empty_i;
      if (!empty_i) begin
        sel_q <= second;
      end
    end
  end

endmodule

// File: test/tb.sv
// Testbench of the primitive topology assembler: streams index lists through every
// primitive mode, predicts each face in step with the input and checks the output.
// Depends on pta_pkg and primitive_topology_assembler_top.
module tb;
  import pta_pkg::*;

  // Mode 7 has no name in the package; the block must flag it.
  localparam logic [2:0] MODE_INVALID = 3'd7;
  localparam logic [2:0] MODE_ADDR    = 3'(4 * REG_MODE);

  localparam int unsigned RANDOM_ITEMS  = 1700;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned DRAIN_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 8;

  // Receiver stall styles.
  localparam int unsigned READY_ALWAYS   = 0;
  localparam int unsigned READY_HALF     = 1;
  localparam int unsigned READY_MOSTLY   = 2;
  localparam int unsigned READY_SPARSE   = 3;
  localparam int unsigned READY_PERIODIC = 4;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] vertex_index_i;
  logic        end_of_list_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] vertex_a_o;
  logic [31:0] vertex_b_o;
  logic [31:0] vertex_c_o;
  logic [1:0]  vertices_in_face_o;
  logic        last_result_o;
  logic [1:0]  status_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  primitive_topology_assembler_top i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .vertex_index_i     (vertex_index_i),
    .end_of_list_i      (end_of_list_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .vertex_a_o         (vertex_a_o),
    .vertex_b_o         (vertex_b_o),
    .vertex_c_o         (vertex_c_o),
    .vertices_in_face_o (vertices_in_face_o),
    .last_result_o      (last_result_o),
    .status_o           (status_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // Predicted list state and the mode register as the block should hold them.
  logic [2:0] cfg_mode;
  index_t     head_idx;
  index_t     prev2_idx;
  index_t     prev1_idx;
  logic [1:0] idx_count;
  logic [1:0] slot_phase;
  logic       winding_fwd;

  // Faces still owed by the block, oldest first.
  result_t expected_faces [$];

  int unsigned mismatch_count;
  int unsigned burst_left;
  bit          gaps_off;
  bit          hold_request;

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t: %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic result_t make_result(index_t a, index_t b, index_t c,
                                          logic [1:0] n, logic last, logic [1:0] st);
    result_t r;
    r.a      = a;
    r.b      = b;
    r.c      = c;
    r.n      = n;
    r.last   = last;
    r.status = st;
    return r;
  endfunction

  // Work out the faces that one accepted index causes and queue them.
  task automatic assemble_faces(input index_t v, input logic eol);
    result_t    made [$];
    logic [1:0] err;
    index_t     head;
    err  = ST_OK;
    // The first index of a list becomes the fan center and loop start.
    head = (idx_count == 0) ? v : head_idx;
    case (cfg_mode)
      MODE_POINTS: begin
        made.push_back(make_result(v, '0, '0, 2'd1, 1'b0, ST_OK));
        slot_phase = 2'd0;
      end
      MODE_LINES: begin
        if (slot_phase[0]) begin
          made.push_back(make_result(prev1_idx, v, '0, 2'd2, 1'b0, ST_OK));
          slot_phase = 2'd0;
        end else begin
          slot_phase = 2'd1;
          if (eol) err = ST_COUNT;
        end
      end
      MODE_TRIS: begin
        if (slot_phase >= 2'd2) begin
          made.push_back(make_result(prev2_idx, prev1_idx, v, 2'd3, 1'b0, ST_OK));
          slot_phase = 2'd0;
        end else begin
          slot_phase = slot_phase + 2'd1;
          if (eol) err = ST_COUNT;
        end
      end
      MODE_STRIP, MODE_LOOP: begin
        slot_phase = 2'd0;
        if (idx_count >= 2'd1) begin
          made.push_back(make_result(prev1_idx, v, '0, 2'd2, 1'b0, ST_OK));
          // Close the loop back to its first index.
          if (eol && cfg_mode == MODE_LOOP) begin
            made.push_back(make_result(v, head, '0, 2'd2, 1'b0, ST_OK));
          end
        end else if (eol) begin
          err = ST_COUNT;
        end
      end
      MODE_TSTRIP: begin
        slot_phase = 2'd0;
        if (idx_count >= 2'd2) begin
          if (winding_fwd) begin
            made.push_back(make_result(prev2_idx, prev1_idx, v, 2'd3, 1'b0, ST_OK));
          end else begin
            made.push_back(make_result(prev2_idx, v, prev1_idx, 2'd3, 1'b0, ST_OK));
          end
          winding_fwd = ~winding_fwd;
        end else if (eol) begin
          err = ST_COUNT;
        end
      end
      MODE_FAN: begin
        slot_phase = 2'd0;
        if (idx_count >= 2'd2) begin
          made.push_back(make_result(head, prev1_idx, v, 2'd3, 1'b0, ST_OK));
        end else if (eol) begin
          err = ST_COUNT;
        end
      end
      default: begin
        slot_phase = 2'd0;
        if (eol) err = ST_BAD_MODE;
      end
    endcase
    if (eol) begin
      if (err != ST_OK) begin
        made.push_back(make_result('0, '0, '0, 2'd0, 1'b1, err));
      end else if (made.size() > 0) begin
        made[made.size()-1].last = 1'b1;
      end
      head_idx    = '0;
      prev2_idx   = '0;
      prev1_idx   = '0;
      idx_count   = 2'd0;
      slot_phase  = 2'd0;
      winding_fwd = 1'b1;
    end else begin
      head_idx  = head;
      prev2_idx = prev1_idx;
      prev1_idx = v;
      if (idx_count < 2'd3) idx_count = idx_count + 2'd1;
    end
    foreach (made[k]) expected_faces.push_back(made[k]);
  endtask

  // Offer one index; between bursts drop valid for a random gap first.
  task automatic send_index(input index_t idx, input logic eol);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_off) gap = 0;
      else if ($urandom_range(0, 7) == 0) gap = $urandom_range(6, 14);
      else gap = $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    vertex_index_i <= idx;
    end_of_list_i  <= eol;
    do @(posedge clk_i); while (!in_ready_o);
    assemble_faces(idx, eol);
  endtask

  // Stop offering, wait for every owed face, then let the pipeline settle.
  task automatic drain_results();
    int unsigned waited;
    in_valid_i <= 1'b0;
    burst_left = 0;
    waited     = 0;
    while (expected_faces.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_faces.size() != 0) begin
      report_mismatch("faces never delivered", expected_faces.size(), 0);
      expected_faces.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic read_mode(output logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MODE_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the mode with junk in the unused bits, then read it back.
  task automatic write_mode(input logic [2:0] mode);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= ($urandom() & ~32'h7) | 32'(mode);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_mode = mode;
    read_mode(readback);
    if (readback[2:0] !== mode) report_mismatch("mode readback", readback, 32'(mode));
  endtask

  function automatic index_t random_index();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return index_t'($urandom_range(0, 15));
      default: return index_t'($urandom());
    endcase
  endfunction

  function automatic logic [2:0] pick_mode();
    logic [2:0] m;
    m = 3'($urandom_range(0, 7));
    // Keep the ignored mode rarer than the others.
    if (m == MODE_INVALID && $urandom_range(0, 1) == 1) m = 3'($urandom_range(0, 6));
    return m;
  endfunction

  // Mostly lengths that fit the mode; one list in five is random noise.
  function automatic int unsigned pick_list_len(logic [2:0] mode);
    int unsigned len;
    len = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 24 : 7);
    if ($urandom_range(0, 4) != 0) begin
      case (mode)
        MODE_LINES:            len = 2 * ((len + 1) / 2);
        MODE_TRIS:             len = 3 * ((len + 2) / 3);
        MODE_STRIP, MODE_LOOP: if (len < 2) len = 2;
        MODE_TSTRIP, MODE_FAN: if (len < 3) len = 3;
        default:               len = len;
      endcase
    end
    return len;
  endfunction

  // Check each output transfer against the oldest owed face.
  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin : face_checker
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_faces.size() == 0) begin
        report_mismatch("face with none expected", vertex_a_o, 0);
      end else begin
        want = expected_faces.pop_front();
        check_field("vertex_a", vertex_a_o, want.a);
        check_field("vertex_b", vertex_b_o, want.b);
        check_field("vertex_c", vertex_c_o, want.c);
        check_field("vertices_in_face", 32'(vertices_in_face_o), 32'(want.n));
        check_field("last_result", 32'(last_result_o), 32'(want.last));
        check_field("status", 32'(status_o), 32'(want.status));
      end
    end
  end

  // Receiver: switch stall style now and then; on request hold off for a
  // long stretch so the block's queue fills and input ready drops.
  int unsigned stall_style;
  int unsigned style_left;
  int unsigned hold_left;
  int unsigned stall_period;
  int unsigned tick;

  always @(posedge clk_i) begin : out_stall_pattern
    tick++;
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style  = $urandom_range(READY_ALWAYS, READY_PERIODIC);
        stall_period = $urandom_range(2, 5);
        style_left   = $urandom_range(10, 80);
      end else begin
        style_left--;
      end
      case (stall_style)
        READY_ALWAYS:   out_ready_i <= 1'b1;
        READY_HALF:     out_ready_i <= ($urandom_range(0, 1) == 1);
        READY_MOSTLY:   out_ready_i <= ($urandom_range(0, 3) != 0);
        READY_SPARSE:   out_ready_i <= ($urandom_range(0, 3) == 0);
        default:        out_ready_i <= (tick % stall_period == 0);
      endcase
    end
  end

  // Read the reset mode and run a triangle list under it.
  task automatic test_reset_state();
    logic [31:0] mode_word;
    read_mode(mode_word);
    if (mode_word[2:0] !== MODE_RESET) report_mismatch("reset mode", mode_word, 32'(MODE_RESET));
    cfg_mode = MODE_RESET;
    send_index('0, 1'b0);
    send_index('1, 1'b0);
    send_index(32'hAAAA_AAAA, 1'b1);
    drain_results();
  endtask

  // Short lists in every mode: short lists, loop closure, winding, fan center,
  // a mode switch in the middle of a list and the unknown mode.
  task automatic test_directed_lists();
    write_mode(MODE_POINTS);
    send_index(32'h5555_5555, 1'b1);
    drain_results();
    // Leave a lines list open with one index pending, then end it as triangles.
    write_mode(MODE_LINES);
    send_index(32'd1, 1'b0);
    send_index(32'd2, 1'b0);
    send_index(32'd3, 1'b0);
    drain_results();
    write_mode(MODE_TRIS);
    send_index(32'd4, 1'b1);
    drain_results();
    write_mode(MODE_STRIP);
    send_index(32'd7, 1'b1);
    drain_results();
    write_mode(MODE_LOOP);
    send_index('1, 1'b0);
    send_index('0, 1'b1);
    drain_results();
    write_mode(MODE_TSTRIP);
    for (int k = 1; k <= 5; k++) send_index(index_t'(k), k == 5);
    drain_results();
    write_mode(MODE_FAN);
    send_index(32'd9, 1'b0);
    send_index(32'd8, 1'b1);
    send_index(32'd9, 1'b0);
    send_index(32'd8, 1'b0);
    send_index(32'd7, 1'b1);
    drain_results();
    write_mode(MODE_INVALID);
    send_index(32'd1, 1'b0);
    send_index(32'd2, 1'b1);
    drain_results();
  endtask

  // Keep offering points while the receiver holds off.
  task automatic test_backpressure();
    write_mode(MODE_POINTS);
    hold_request = 1'b1;
    gaps_off     = 1'b1;
    for (int k = 0; k < 30; k++) send_index(random_index(), k == 29);
    gaps_off = 1'b0;
    drain_results();
  endtask

  // Phases of random lists under a random mode; some phases end with the
  // list still open so the next mode picks it up.
  task automatic test_random_lists();
    int unsigned sent;
    int unsigned phase_items;
    int unsigned len;
    bit          open_tail;
    bit          cut;
    logic        eol;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      write_mode(pick_mode());
      phase_items = $urandom_range(30, 120);
      open_tail   = ($urandom_range(0, 3) == 0);
      gaps_off    = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) hold_request = 1'b1;
      while (phase_items > 0) begin
        len = pick_list_len(cfg_mode);
        cut = open_tail && len >= phase_items;
        if (cut) len = phase_items;
        for (int k = 0; k < len; k++) begin
          eol = !cut && (k == len - 1);
          send_index(random_index(), eol);
          // Indices the unknown mode drops do not count.
          if (cfg_mode != MODE_INVALID || eol) sent++;
        end
        phase_items = (len >= phase_items) ? 0 : phase_items - len;
      end
    end
    gaps_off = 1'b0;
  endtask

  initial begin : run_tests
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    vertex_index_i = '0;
    end_of_list_i  = 1'b0;
    out_ready_i    = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatch_count = 0;
    burst_left     = 0;
    gaps_off       = 1'b0;
    hold_request   = 1'b0;
    stall_style    = READY_ALWAYS;
    style_left     = 0;
    hold_left      = 0;
    stall_period   = 2;
    tick           = 0;
    cfg_mode       = MODE_RESET;
    head_idx       = '0;
    prev2_idx      = '0;
    prev1_idx      = '0;
    idx_count      = 2'd0;
    slot_phase     = 2'd0;
    winding_fwd    = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed_lists();
    test_backpressure();
    test_random_lists();
    drain_results();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: a correct run needs a small fraction of this.
  initial begin : watchdog
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: primitive_topology_assembler_top.f
design/pta_pkg.sv
design/pta_front.sv
design/pta_fifo.sv
design/pta_back.sv
design/primitive_topology_assembler_top.sv
test/tb.sv
